// File: hw/rtl/sfas_pkg.sv
package sfas_pkg;

    localparam int unsigned FRAC_W = 23;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned SIG_W  = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADD,
        ST_NORM,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/single_float_add_sub_truncating_top.sv
// single-precision add/subtract with truncation. one word in on func/operand_a/operand_b,
// one word out on result/range_error. subtract flips the sign of operand_b; operands
// are ordered by magnitude, the smaller significand is aligned by a truncating right
// shift (an extra unit is taken off in a subtraction when the top shifted-out bit is 1),
// and the difference is normalized one bit a cycle. a word passes through the align, add,
// normalize and done states; alignment shifts one bit per exponent step (at most 25 steps)
// and left normalization shifts one bit per step (at most 23 steps). zero operands and
// equal opposite magnitudes go straight from idle to done.
// the input is not ready while a word is in flight or its result waits. NaN, infinity
// and subnormals are treated as ordinary numbers; range_error flags an exponent
// outside 1..254, with the exponent field holding it modulo 256.
module single_float_add_sub_truncating_top
    import sfas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result,
    output logic        range_error
);

    state_t state_reg, state_next;

    // datapath registers
    logic              sgn_reg, sgn_next;
    logic              sub_reg, sub_next;
    logic signed [9:0] e_reg, e_next;
    logic [4:0]        d_reg, d_next;       // remaining alignment steps
    logic [SIG_W-1:0]  m1_reg, m1_next;
    logic [SIG_W-1:0]  m2_reg, m2_next;
    logic              guard_reg, guard_next; // last bit shifted out
    logic [SIG_W:0]    res_reg, res_next;
    logic [31:0]       result_reg, result_next;
    logic              err_reg, err_next;

    // input decode
    logic [31:0] b_eff;
    logic [30:0] mag_a, mag_b;
    logic        a_big;
    logic [31:0] big, lesser;
    logic [EXP_W-1:0] d_full;

    always_comb
    begin
        b_eff  = {operand_b[31] ^ func, operand_b[30:0]};
        mag_a  = operand_a[30:0];
        mag_b  = b_eff[30:0];
        a_big  = (mag_a >= mag_b);
        big    = a_big ? operand_a : b_eff;
        lesser = a_big ? b_eff : operand_a;
        d_full = big[30:23] - lesser[30:23];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mag_a == mag_b && operand_a[31] != b_eff[31])
                        state_next = ST_DONE;
                    else if (mag_a == '0 || mag_b == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
                if (d_reg == '0) state_next = ST_ADD;
            ST_ADD:
                state_next = ST_NORM;
            ST_NORM:
            begin
                if (!sub_reg || res_reg == '0 || res_reg[SIG_W-1])
                    state_next = ST_DONE;
            end
            ST_DONE:
                if (out_ready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        sgn_next    = sgn_reg;
        sub_next    = sub_reg;
        e_next      = e_reg;
        d_next      = d_reg;
        m1_next     = m1_reg;
        m2_next     = m2_reg;
        guard_next  = guard_reg;
        res_next    = res_reg;
        result_next = result_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                err_next = 1'b0;
                if (mag_a == mag_b && operand_a[31] != b_eff[31])
                    result_next = '0;
                else if (mag_a == '0)
                    result_next = b_eff;
                else if (mag_b == '0)
                    result_next = operand_a;
                sgn_next   = big[31];
                sub_next   = big[31] ^ lesser[31];
                e_next     = signed'({2'b00, big[30:23]});
                // shifts of 25 or more leave the same state as 25 steps
                d_next     = (d_full > 8'd25) ? 5'd25 : d_full[4:0];
                m1_next    = {1'b1, big[FRAC_W-1:0]};
                m2_next    = {1'b1, lesser[FRAC_W-1:0]};
                guard_next = 1'b0;
            end
            ST_ALIGN:
            begin
                if (d_reg != '0)
                begin
                    guard_next = m2_reg[0];
                    m2_next    = m2_reg >> 1;
                    d_next     = d_reg - 5'd1;
                end
            end
            ST_ADD:
            begin
                if (!sub_reg)
                    res_next = {1'b0, m1_reg} + {1'b0, m2_reg};
                else
                    res_next = {1'b0, m1_reg} - {1'b0, m2_reg} - {{SIG_W{1'b0}}, guard_reg};
            end
            ST_NORM:
            begin
                if (!sub_reg)
                begin
                    if (res_reg[SIG_W])
                    begin
                        res_next = res_reg >> 1;
                        e_next   = e_reg + 10'sd1;
                    end
                end
                else if (res_reg != '0 && !res_reg[SIG_W-1])
                begin
                    res_next = res_reg << 1;
                    e_next   = e_reg - 10'sd1;
                end
            end
            default:
            begin
            end
        endcase
        // finishing the normalize step forms the result word
        if (state_reg == ST_NORM && state_next == ST_DONE)
        begin
            if (sub_reg && res_reg == '0)
            begin
                result_next = '0;
                err_next    = 1'b0;
            end
            else
            begin
                result_next = {sgn_reg, e_next[7:0], res_next[FRAC_W-1:0]};
                err_next    = (e_next < 10'sd1) || (e_next > 10'sd254);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sgn_reg    <= sgn_next;
        sub_reg    <= sub_next;
        e_reg      <= e_next;
        d_reg      <= d_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        guard_reg  <= guard_next;
        res_reg    <= res_next;
        result_reg <= result_next;
        err_reg    <= err_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign result      = result_reg;
    assign range_error = err_reg;

endmodule

// File: verif/tb_single_float_add_sub_truncating_top.sv
`timescale 1ns / 1ps

module tb_single_float_add_sub_truncating_top;
    import sfas_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK = 32'h7fff_ffff;
    localparam logic [23:0] HIDDEN = 24'h80_0000;
    localparam logic FN_ADD = 1'b0;
    localparam logic FN_SUB = 1'b1;

    typedef struct packed {
        logic [31:0] sum;
        logic        range_err;
    } fp_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result;
    logic        range_error;

    fp_result_t  pending_sums[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    bit          sink_stall_mode;

    single_float_add_sub_truncating_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result),
        .range_error (range_error)
    );

    // free-running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predicted sum or difference, truncated, with the range flag
    function automatic fp_result_t fp_add_sub(input logic fn, input logic [31:0] x,
                                              input logic [31:0] y);
        fp_result_t  r;
        logic [31:0] big;
        logic [31:0] little;
        logic [7:0]  dexp;
        logic [23:0] sig_big;
        logic [23:0] sig_small;
        logic [24:0] acc;
        logic        borrow;
        int          e;
        if (fn == FN_SUB)
            y = y ^ SIGN_MASK;
        r = '0;
        // equal magnitudes of opposite sign cancel to +0
        if ((x & MAG_MASK) == (y & MAG_MASK) && ((x ^ y) & SIGN_MASK) != 0)
            return r;
        // a zero operand passes the other one through
        if ((x & MAG_MASK) == 0)
        begin
            r.sum = y;
            return r;
        end
        if ((y & MAG_MASK) == 0)
        begin
            r.sum = x;
            return r;
        end
        if ((x & MAG_MASK) >= (y & MAG_MASK))
        begin
            big = x;
            little = y;
        end
        else
        begin
            big = y;
            little = x;
        end
        e = int'(big[30:23]);
        dexp = big[30:23] - little[30:23];
        sig_big = {1'b1, big[22:0]};
        sig_small = {1'b1, little[22:0]};
        borrow = 1'b0;
        if (dexp >= 1 && dexp <= 24)
            borrow = sig_small[dexp - 1];
        sig_small = (dexp < 24) ? (sig_small >> dexp) : 24'd0;
        if (big[31] == little[31])
        begin
            acc = {1'b0, sig_big} + {1'b0, sig_small};
            if (acc[24])
            begin
                acc = acc >> 1;
                e = e + 1;
            end
        end
        else
        begin
            acc = {1'b0, sig_big} - {1'b0, sig_small} - {24'd0, borrow};
            // borrow can wipe out a one-unit difference
            if (acc == 0)
                return r;
            while (acc[23:0] < HIDDEN)
            begin
                acc = acc << 1;
                e = e - 1;
            end
        end
        r.range_err = (e < 1 || e > 254);
        r.sum = {big[31], e[7:0], acc[22:0]};
        return r;
    endfunction

    // push one word through the input handshake, predicting its result on acceptance
    task automatic send_word(input logic fn, input logic [31:0] x, input logic [31:0] y);
        int unsigned gap;
        // burst/gap pacing on the sender side
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= fn;
        operand_a <= x;
        operand_b <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_sums.push_back(fp_add_sub(fn, x, y));
        @(negedge clk);
    endtask

    // pause until every word in flight has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] fp_pack(input logic s, input logic [7:0] ex,
                                           input logic [22:0] fr);
        return {s, ex, fr};
    endfunction

    // extremes of every field, both operations, each special case
    task automatic test_directed();
        send_word(FN_ADD, 32'h0000_0000, 32'h0000_0000);
        send_word(FN_SUB, 32'h0000_0000, 32'h0000_0000);      // +0 - +0 gives +0
        send_word(FN_ADD, 32'h8000_0000, 32'h3f80_0000);      // zero first operand
        send_word(FN_SUB, 32'h4040_0000, 32'h8000_0000);      // zero second operand
        send_word(FN_SUB, 32'h0000_0000, 32'h4000_0000);      // zero minus x flips sign
        send_word(FN_ADD, 32'h3f80_0000, 32'hbf80_0000);      // opposite equal magnitudes
        send_word(FN_SUB, 32'hc2c8_0000, 32'hc2c8_0000);
        send_word(FN_ADD, 32'h3f80_0000, 32'h3f80_0000);      // carry-out renormalize
        send_word(FN_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff);      // exponent overflow
        send_word(FN_SUB, 32'h0080_0001, 32'h0080_0000);      // exponent underflow
        send_word(FN_SUB, 32'h3f80_0000, 32'h3380_0001);      // borrow from shifted-out bit
        send_word(FN_SUB, 32'h3f80_0000, 32'h3f7f_ffff);      // deep cancellation
        send_word(FN_SUB, 32'h4b00_0001, 32'h4aff_ffff);      // borrow leaves one unit
        send_word(FN_ADD, 32'h7fff_ffff, 32'hffff_fffe);      // exponent 255 as ordinary
        send_word(FN_ADD, 32'h0000_0001, 32'h0000_0002);      // exponent 0 as ordinary
        send_word(FN_ADD, 32'h4000_0000, 32'h3300_0000);      // shift of 26
        send_word(FN_ADD, 32'h7f00_0000, 32'h0000_0001);      // huge exponent gap
        send_word(FN_SUB, 32'hffff_ffff, 32'h7fff_ffff);
        send_word(FN_ADD, 32'h3fff_ffff, 32'h3fff_ffff);
        send_word(FN_SUB, 32'h3400_0000, 32'h4000_0000);      // smaller first operand
        wait_drained();
    endtask

    // random words, mostly operands with near exponents so the datapath gets exercised
    task automatic test_random();
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        int unsigned kind;
        for (int i = 0; i < 1230; i++)
        begin
            kind = $urandom_range(0, 9);
            x = $urandom();
            y = $urandom();
            if (kind < 5)
            begin
                ex = x[30:23] + 8'($urandom_range(0, 26)) - 8'd13;
                y = fp_pack(y[31], ex, y[22:0]);
            end
            else if (kind == 5)
                y = fp_pack(y[31], x[30:23], x[22:0] ^ (23'd1 << $urandom_range(0, 22)));
            else if (kind == 6)
                y = fp_pack(y[31], x[30:23], x[22:0]);
            else if (kind == 7)
                y = (y[0]) ? (y & SIGN_MASK) : y;
            // sender waits for a full drain once midway
            if (i == 600)
                wait_drained();
            send_word(1'($urandom()), x, y);
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin
        fp_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result word %h", result);
                error_count++;
            end
            else
            begin
                exp_r = pending_sums.pop_front();
                if (result !== exp_r.sum)
                begin
                    $error("result: expected %h, got %h", exp_r.sum, result);
                    error_count++;
                end
                if (range_error !== exp_r.range_err)
                begin
                    $error("range_error: expected %b, got %b", exp_r.range_err, range_error);
                    error_count++;
                end
            end
        end
    end

    // sink alternates between free-flowing stretches and random stalls
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            sink_stall_mode = ~sink_stall_mode;
        out_ready <= sink_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        sink_stall_mode = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_ADD;
        operand_a = '0;
        operand_b = '0;
        out_ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_sums.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
